// ===== rtl/core/scr_pkg.sv =====
// Shared types, constants and the binomial table of the signed combination rank core.
`default_nettype none

package scr_pkg;

   localparam int ELEM_W      = 5;
   localparam int RANK_W      = 13;
   localparam int ELEM_COUNT  = 4;
   localparam int SUBSET_SIZE = 4;
   localparam int BINOM_ROWS  = 2 ** ELEM_W;
   localparam int BINOM_COLS  = SUBSET_SIZE + 1;
   localparam int COL_W       = $clog2(BINOM_COLS);
   localparam int BOUND_W     = ELEM_W + 2;

   localparam logic [ELEM_W-1:0] POINT_COUNT_RESET = ELEM_W'(20);

   typedef logic [ELEM_W-1:0]  elem_type;
   typedef logic [RANK_W-1:0]  rank_type;
   typedef logic [COL_W-1:0]   col_type;
   typedef logic signed [BOUND_W-1:0] bound_type;

   typedef struct packed {
      elem_type elem_a;
      elem_type elem_b;
      elem_type elem_c;
      elem_type elem_d;
   } req_payload_type;

   typedef struct packed {
      rank_type rank_index;
      logic     odd_order;
   } rsp_payload_type;

   // Sorted elements (index 0 smallest) and swap parity
   typedef struct packed {
      elem_type [ELEM_COUNT-1:0] elems;
      logic                      odd;
   } sort_result_type;

   typedef rank_type [BINOM_COLS-1:0]      binom_row_type;
   typedef binom_row_type [BINOM_ROWS-1:0] binom_table_type;

   // Pascal triangle, kept modulo 2**RANK_W; column r holds C(x, r)
   function automatic binom_table_type build_binom_table();
      binom_table_type t;
      t = '0;
      for (int x = 0; x < BINOM_ROWS; x++) begin
         t[x][0] = RANK_W'(1);
         for (int r = 1; r < BINOM_COLS; r++) begin
            if (x > 0) begin
               t[x][r] = t[x-1][r-1] + t[x-1][r];
            end
         end
      end
      return t;
   endfunction

   localparam binom_table_type BINOM_TABLE = build_binom_table();

endpackage

`default_nettype wire

// ===== rtl/core/signed_combination_rank_core.sv =====
// Top level of the signed combination rank core: sort, lane and merge pipeline.
`default_nettype none

// Ranks a four-element subset of a ground set of csr point_count elements
// (reset 20) and reports the parity of the swaps that order it. The elements
// are sorted and the parity found ahead of the stage 1 register, four lanes
// read the binomial table in parallel from stage 1 into the stage 2 register,
// and the lane terms are added into the result register (stage 3). One request
// is accepted every cycle while rsp_stall is low; req_stall follows rsp_stall
// combinationally through the pipeline.
// Write point_count only while the core holds no request. The rank wraps
// modulo 8192; elements are not range checked.
module signed_combination_rank_core (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           req_valid,
   output logic                          req_stall,
   input  wire scr_pkg::req_payload_type req_payload,
   output logic                          rsp_valid,
   input  wire                           rsp_stall,
   output scr_pkg::rsp_payload_type      rsp_payload,
   input  wire                           csr_wr_en,
   input  wire scr_pkg::elem_type        csr_wr_data
);

   scr_pkg::elem_type        point_count_ff;
   scr_pkg::sort_result_type sort_out;
   scr_pkg::sort_result_type s1_data_ff;
   logic                     s1_valid_ff;
   scr_pkg::rank_type [scr_pkg::ELEM_COUNT-1:0] lane_terms;
   scr_pkg::rank_type [scr_pkg::ELEM_COUNT-1:0] s2_terms_ff;
   logic                     s2_odd_ff;
   logic                     s2_valid_ff;
   scr_pkg::rank_type        merged_rank;
   scr_pkg::rsp_payload_type rsp_payload_ff;
   logic                     rsp_valid_ff;
   logic                     out_free;
   logic                     s2_free;
   logic                     s1_free;
   scr_pkg::bound_type       n_ext;

   // Hold the ground set size
   always_ff @(posedge clock) begin
      if (reset) begin
         point_count_ff <= scr_pkg::POINT_COUNT_RESET;
      end else if (csr_wr_en) begin
         point_count_ff <= csr_wr_data;
      end
   end

   // Advance a stage when the one after it is empty or moving
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s2_free   = !s2_valid_ff || out_free;
   assign s1_free   = !s1_valid_ff || s2_free;
   assign req_stall = !s1_free;

   scr_sort u_sort (
      .req_payload (req_payload),
      .sort_result (sort_out)
   );

   // Stage 1: sorted elements and parity
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_free) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_free) begin
         s1_data_ff <= sort_out;
      end
   end

   assign n_ext = scr_pkg::bound_type'({2'b00, point_count_ff});

   // Lanes: one per sorted element
   for (genvar g = 0; g < scr_pkg::ELEM_COUNT; g++) begin : g_lane
      scr_pkg::bound_type lo_b;
      scr_pkg::bound_type hi_b;
      scr_pkg::col_type   lane_col;

      assign lo_b = n_ext
                  - scr_pkg::bound_type'({2'b00, s1_data_ff.elems[g]})
                  + scr_pkg::bound_type'(1);
      if (g == 0) begin : g_first
         assign hi_b = n_ext;
      end else begin : g_rest
         assign hi_b = n_ext
                     - scr_pkg::bound_type'({2'b00, s1_data_ff.elems[g-1]});
      end
      assign lane_col = (scr_pkg::SUBSET_SIZE > g)
                      ? scr_pkg::COL_W'(scr_pkg::SUBSET_SIZE - g) : '0;

      scr_lane u_lane (
         .lo_bound (lo_b),
         .hi_bound (hi_b),
         .col      (lane_col),
         .term     (lane_terms[g])
      );
   end

   // Stage 2: lane terms
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_free) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_free) begin
         s2_terms_ff <= lane_terms;
         s2_odd_ff   <= s1_data_ff.odd;
      end
   end

   scr_merge u_merge (
      .terms (s2_terms_ff),
      .rank  (merged_rank)
   );

   // Stage 3: result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         rsp_payload_ff.rank_index <= merged_rank;
         rsp_payload_ff.odd_order  <= s2_odd_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

`default_nettype wire

// ===== rtl/core/scr_sort.sv =====
// Four-element sorting network with swap-parity detection.
`default_nettype none

module scr_sort (
   input  wire scr_pkg::req_payload_type req_payload,
   output scr_pkg::sort_result_type      sort_result
);

   scr_pkg::elem_type [scr_pkg::ELEM_COUNT-1:0] raw;
   scr_pkg::elem_type [scr_pkg::ELEM_COUNT-1:0] st1;
   scr_pkg::elem_type [scr_pkg::ELEM_COUNT-1:0] st2;
   logic odd;

   assign raw[0] = req_payload.elem_a;
   assign raw[1] = req_payload.elem_b;
   assign raw[2] = req_payload.elem_c;
   assign raw[3] = req_payload.elem_d;

   // Parity of inverted pairs equals parity of adjacent swaps
   always_comb begin
      odd = 1'b0;
      for (int i = 0; i < scr_pkg::ELEM_COUNT; i++) begin
         for (int j = i + 1; j < scr_pkg::ELEM_COUNT; j++) begin
            odd = odd ^ (raw[i] > raw[j]);
         end
      end
   end

   // Sort: pairs (0,1)(2,3), then (0,2)(1,3), then (1,2)
   always_comb begin
      st1[0] = (raw[0] > raw[1]) ? raw[1] : raw[0];
      st1[1] = (raw[0] > raw[1]) ? raw[0] : raw[1];
      st1[2] = (raw[2] > raw[3]) ? raw[3] : raw[2];
      st1[3] = (raw[2] > raw[3]) ? raw[2] : raw[3];
      st2[0] = (st1[0] > st1[2]) ? st1[2] : st1[0];
      st2[2] = (st1[0] > st1[2]) ? st1[0] : st1[2];
      st2[1] = (st1[1] > st1[3]) ? st1[3] : st1[1];
      st2[3] = (st1[1] > st1[3]) ? st1[1] : st1[3];
      sort_result.elems[0] = st2[0];
      sort_result.elems[1] = (st2[1] > st2[2]) ? st2[2] : st2[1];
      sort_result.elems[2] = (st2[1] > st2[2]) ? st2[1] : st2[2];
      sort_result.elems[3] = st2[3];
      sort_result.odd      = odd;
   end

endmodule

`default_nettype wire

// ===== rtl/core/scr_lane.sv =====
// One ranking lane: binomial range sum via hockey-stick difference.
`default_nettype none

module scr_lane (
   input  wire scr_pkg::bound_type lo_bound,
   input  wire scr_pkg::bound_type hi_bound,
   input  wire scr_pkg::col_type   col,
   output scr_pkg::rank_type       term
);

   logic [scr_pkg::ELEM_W-1:0] lo_idx;
   logic [scr_pkg::ELEM_W-1:0] hi_idx;

   // Clamp negative bounds to zero, since C(j, m) vanishes for negative j
   assign lo_idx = lo_bound[scr_pkg::BOUND_W-1] ? '0 : lo_bound[scr_pkg::ELEM_W-1:0];
   assign hi_idx = hi_bound[scr_pkg::BOUND_W-1] ? '0 : hi_bound[scr_pkg::ELEM_W-1:0];

   // Sum of C(j, col-1) for lo <= j < hi is C(hi, col) - C(lo, col)
   always_comb begin
      if ((col != '0) && (lo_bound < hi_bound)) begin
         term = scr_pkg::BINOM_TABLE[hi_idx][col] - scr_pkg::BINOM_TABLE[lo_idx][col];
      end else begin
         term = '0;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/scr_merge.sv =====
// Merge stage: adds the lane terms to the base rank of one.
`default_nettype none

module scr_merge (
   input  wire scr_pkg::rank_type [scr_pkg::ELEM_COUNT-1:0] terms,
   output scr_pkg::rank_type                                rank
);

   // Accumulate modulo 2**RANK_W
   always_comb begin
      rank = scr_pkg::RANK_W'(1);
      for (int i = 0; i < scr_pkg::ELEM_COUNT; i++) begin
         rank = rank + terms[i];
      end
   end

endmodule

`default_nettype wire
